@@ rtl/core/kekt_pkg.sv @@
// shared types, key tables and key positions for the key event translator
`default_nettype none

package kekt_pkg;

  localparam int NUM_KEYS = 56;
  localparam int KEY_IDX_W = 6;

  // configuration register indexes
  localparam logic CFG_EVENT_OUT_EN = 1'b0;
  localparam logic CFG_NAV_OUT_EN   = 1'b1;

  // logical key positions (row * 14 + col)
  localparam logic [KEY_IDX_W-1:0] KEY_SHIFT = 6'd28;
  localparam logic [KEY_IDX_W-1:0] KEY_CAPS  = 6'd29;
  localparam logic [KEY_IDX_W-1:0] KEY_CTRL  = 6'd42;
  localparam logic [KEY_IDX_W-1:0] KEY_OPT   = 6'd43;
  localparam logic [KEY_IDX_W-1:0] KEY_ALT   = 6'd44;
  localparam logic [KEY_IDX_W-1:0] KEY_UP    = 6'd39;
  localparam logic [KEY_IDX_W-1:0] KEY_ENTER = 6'd41;
  localparam logic [KEY_IDX_W-1:0] KEY_LEFT  = 6'd52;
  localparam logic [KEY_IDX_W-1:0] KEY_DOWN  = 6'd53;
  localparam logic [KEY_IDX_W-1:0] KEY_RIGHT = 6'd54;

  // modifier bit positions
  localparam int MOD_SHIFT_BIT = 0;
  localparam int MOD_CTRL_BIT  = 1;
  localparam int MOD_ALT_BIT   = 2;
  localparam int MOD_OPT_BIT   = 3;

  // navigation codes
  localparam logic [2:0] NAV_NONE  = 3'd0;
  localparam logic [2:0] NAV_UP    = 3'd1;
  localparam logic [2:0] NAV_DOWN  = 3'd2;
  localparam logic [2:0] NAV_LEFT  = 3'd3;
  localparam logic [2:0] NAV_RIGHT = 3'd4;
  localparam logic [2:0] NAV_ENTER = 3'd5;

  // hid ranges and modifier usages
  localparam logic [7:0] HID_LETTER_LO = 8'h04;
  localparam logic [7:0] HID_LETTER_HI = 8'h1D;
  localparam logic [7:0] HID_CAPS      = 8'h39;
  localparam logic [7:0] HID_LCTRL     = 8'hE0;
  localparam logic [7:0] HID_LSHIFT    = 8'hE1;
  localparam logic [7:0] HID_LALT      = 8'hE2;
  localparam logic [7:0] HID_LGUI      = 8'hE3;

  localparam logic [7:0] HID_TAB [NUM_KEYS] = '{
    8'h35, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h2E, 8'h2A,
    8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18, 8'h0C, 8'h12, 8'h13, 8'h2F, 8'h30, 8'h31,
    8'hE1, 8'h39, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h33, 8'h34, 8'h28,
    8'hE0, 8'hE3, 8'hE2, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'h2C
  };

  localparam logic [6:0] PLAIN_TAB [NUM_KEYS] = '{
    7'h60, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00,
    7'h00, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h5C,
    7'h00, 7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B, 7'h27, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h20
  };

  localparam logic [6:0] SHIFT_TAB [NUM_KEYS] = '{
    7'h7E, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h00,
    7'h00, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h7C,
    7'h00, 7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A, 7'h22, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h20
  };

  // decoded key position and table entries
  typedef struct packed {
    logic                 valid;
    logic [KEY_IDX_W-1:0] idx;
    logic [7:0]           hid;
    logic [6:0]           plain_char;
    logic [6:0]           shift_char;
  } key_info_t;

  // one result beat, last field in the lowest bits
  typedef struct packed {
    logic       caps_state;
    logic [3:0] modifiers_now;
    logic [2:0] nav_key;
    logic [6:0] char_code;
    logic [7:0] hid_code;
    logic       is_modifier_key;
    logic       is_press;
    logic       event_valid;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

@@ rtl/core/kekt_decode.sv @@
// raw key code to logical key position and key table lookup
`default_nettype none

module kekt_decode (
  input  wire logic [6:0]          code,
  output kekt_pkg::key_info_t      info
);
  import kekt_pkg::*;

  logic [6:0]  code_m1;
  logic [14:0] recip_prod;
  logic [3:0]  raw_row;
  logic [6:0]  row_x10;
  logic [6:0]  raw_col;
  logic [1:0]  lrow;
  logic [3:0]  lcol;
  logic [5:0]  row_base;
  logic [5:0]  idx;

  // divide by 10 through reciprocal multiply, exact for values below 1029
  assign code_m1    = code - 7'd1;
  assign recip_prod = {8'd0, code_m1} * 15'd205;
  assign raw_row    = recip_prod[14:11];
  assign row_x10    = {raw_row, 3'b000} + {2'b00, raw_row, 1'b0};
  assign raw_col    = code_m1 - row_x10;

  // fold 7x8 raw matrix onto 4x14 logical layout
  assign lrow = raw_col[1:0];
  assign lcol = {raw_row[2:0], 1'b0} + {3'd0, raw_col[2]};

  always_comb begin
    unique case (lrow)
      2'd0: row_base = 6'd0;
      2'd1: row_base = 6'd14;
      2'd2: row_base = 6'd28;
      2'd3: row_base = 6'd42;
      default: row_base = 6'd0;
    endcase
  end

  assign idx = row_base + {2'b00, lcol};

  // table lookup, index stays below 56 whenever the position is in range
  always_comb begin
    info.valid      = (code != 7'd0) && (raw_row < 4'd7) && (raw_col < 7'd8);
    info.idx        = idx;
    info.hid        = 8'd0;
    info.plain_char = 7'd0;
    info.shift_char = 7'd0;
    if (idx < 6'(NUM_KEYS)) begin
      info.hid        = HID_TAB[idx];
      info.plain_char = PLAIN_TAB[idx];
      info.shift_char = SHIFT_TAB[idx];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/key_event_to_keycode_translator_core.sv @@
// key event translator top level: input register, key state update, result register
// an accepted beat passes the input register and then the result register before the master side offers it
// throughput: one beat per cycle; input register, state update and result register
// all advance together, so only master-side backpressure slows the block
// reset: synchronous active-high rst clears the pressed map, modifiers, caps lock,
// both enables and all valid flags
`default_nettype none

module key_event_to_keycode_translator_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration write port
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic                            cfg_data,
  // slave side
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [7:0]                      s_tdata,  // [7:0] event_byte
  // master side
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [0] event_valid, [1] is_press, [2] is_modifier_key, [10:3] hid_code,
  // [17:11] char_code, [20:18] nav_key, [24:21] modifiers_now, [25] caps_state
  output logic [kekt_pkg::OUT_DATA_W-1:0]      m_tdata
);
  import kekt_pkg::*;

  logic                event_out_enable;
  logic                nav_out_enable;
  logic                in_valid;
  logic [7:0]          in_byte;
  logic                out_valid;
  result_t             out_data;
  logic [NUM_KEYS-1:0] pressed_map;
  logic [NUM_KEYS-1:0] pressed_map_next;
  logic [3:0]          modifier_bits;
  logic [3:0]          modifier_bits_next;
  logic                caps_on;
  logic                caps_on_next;
  key_info_t           key;
  logic                press;
  logic                key_held;
  logic                accept_key;
  logic                advance;
  logic                is_mod;
  logic                letter_key;
  logic                use_shift;
  logic [6:0]          char_sel;
  logic [2:0]          nav_sel;
  logic [2:0]          nav;
  logic                emit;
  result_t             res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      event_out_enable <= 1'b0;
      nav_out_enable   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EVENT_OUT_EN: event_out_enable <= cfg_data;
        CFG_NAV_OUT_EN:   nav_out_enable   <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake: input register moves whenever the result register is free
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  kekt_decode u_decode (
    .code (in_byte[6:0]),
    .info (key)
  );

  // drop unknown positions and repeated presses or releases
  assign press       = in_byte[7];
  assign key_held    = pressed_map[key.idx];
  assign accept_key  = key.valid && (key_held != press);

  // next key state
  always_comb begin
    pressed_map_next   = pressed_map;
    modifier_bits_next = modifier_bits;
    caps_on_next       = caps_on;
    if (accept_key) begin
      pressed_map_next[key.idx] = press;
      priority if (key.idx == KEY_SHIFT) begin
        modifier_bits_next[MOD_SHIFT_BIT] = press;
      end else if (key.idx == KEY_CTRL) begin
        modifier_bits_next[MOD_CTRL_BIT] = press;
      end else if (key.idx == KEY_ALT) begin
        modifier_bits_next[MOD_ALT_BIT] = press;
      end else if (key.idx == KEY_OPT) begin
        modifier_bits_next[MOD_OPT_BIT] = press;
      end else if (key.idx == KEY_CAPS) begin
        caps_on_next = caps_on ^ press;
      end else begin
        caps_on_next = caps_on;
      end
    end
  end

  // character select after shift and caps rules
  assign is_mod = (key.hid == HID_LCTRL) || (key.hid == HID_LSHIFT) ||
                  (key.hid == HID_LALT) || (key.hid == HID_LGUI) || (key.hid == HID_CAPS);
  assign letter_key = (key.hid >= HID_LETTER_LO) && (key.hid <= HID_LETTER_HI);
  assign use_shift = letter_key ? (modifier_bits_next[MOD_SHIFT_BIT] ^ caps_on_next)
                                : modifier_bits_next[MOD_SHIFT_BIT];
  assign char_sel  = is_mod ? 7'd0 : (use_shift ? key.shift_char : key.plain_char);

  // navigation key on press
  always_comb begin
    priority if (key.idx == KEY_UP) begin
      nav_sel = NAV_UP;
    end else if (key.idx == KEY_DOWN) begin
      nav_sel = NAV_DOWN;
    end else if (key.idx == KEY_LEFT) begin
      nav_sel = NAV_LEFT;
    end else if (key.idx == KEY_RIGHT) begin
      nav_sel = NAV_RIGHT;
    end else if (key.idx == KEY_ENTER) begin
      nav_sel = NAV_ENTER;
    end else begin
      nav_sel = NAV_NONE;
    end
  end

  assign nav  = (press && nav_out_enable) ? nav_sel : NAV_NONE;
  assign emit = accept_key && (event_out_enable || (nav != NAV_NONE));

  // result beat
  always_comb begin
    res.event_valid     = event_out_enable;
    res.is_press        = event_out_enable & press;
    res.is_modifier_key = event_out_enable & is_mod;
    res.hid_code        = event_out_enable ? key.hid : 8'd0;
    res.char_code       = event_out_enable ? char_sel : 7'd0;
    res.nav_key         = nav;
    res.modifiers_now   = modifier_bits_next;
    res.caps_state      = caps_on_next;
  end

  // key state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_map   <= '0;
      modifier_bits <= 4'd0;
      caps_on       <= 1'b0;
    end else if (advance) begin
      pressed_map   <= pressed_map_next;
      modifier_bits <= modifier_bits_next;
      caps_on       <= caps_on_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_data <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_DATA_W'(out_data);

  // modifier bits mirror the pressed state of their keys
  a_mod_mirror: assert property (@(posedge clk) disable iff (rst)
    (modifier_bits[MOD_SHIFT_BIT] == pressed_map[KEY_SHIFT]) &&
    (modifier_bits[MOD_CTRL_BIT] == pressed_map[KEY_CTRL]) &&
    (modifier_bits[MOD_ALT_BIT] == pressed_map[KEY_ALT]) &&
    (modifier_bits[MOD_OPT_BIT] == pressed_map[KEY_OPT]))
    else $error("modifier bits out of step with pressed map");

  // key state only moves when a beat leaves the input register
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(pressed_map) && $stable(modifier_bits) && $stable(caps_on))
    else $error("key state changed without an input beat");

  // a beat without event fields exists only for a navigation key
  a_nav_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.event_valid |->
      (out_data.nav_key != NAV_NONE) && (out_data.hid_code == 8'd0) &&
      (out_data.char_code == 7'd0) && !out_data.is_press)
    else $error("navigation-only beat carries event fields");

  // modifier keys never carry a character
  a_mod_no_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_modifier_key |-> out_data.char_code == 7'd0)
    else $error("modifier key beat carries a character");

endmodule

`default_nettype wire

@@ test/tb_key_event_to_keycode_translator_core.sv @@
// self-checking testbench for the key event translator core
module tb_key_event_to_keycode_translator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import kekt_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 8;
  localparam int NUM_PHASES = 7;
  localparam int MIN_PHASE_HITS = 40;
  localparam int TAB_HOLE = 8'h09;

  // per-phase enables, idle rates and minimum number of beats sent
  localparam int PH_EVENT [NUM_PHASES]     = '{1, 1, 0, 1, 0, 1, 1};
  localparam int PH_NAV [NUM_PHASES]       = '{1, 0, 1, 1, 0, 0, 1};
  localparam int PH_SEND_IDLE [NUM_PHASES] = '{0, 46, 0, 34, 34, 0, 46};
  localparam int PH_STALL [NUM_PHASES]     = '{0, 0, 46, 34, 34, 46, 0};
  localparam int PH_ITEMS [NUM_PHASES]     = '{300, 300, 250, 300, 100, 200, 200};
  localparam int PAUSE_PHASE = 3;

  // key codes of modifiers, caps lock and navigation keys, picked more often
  localparam logic [6:0] HOT_CODES [10] = '{
    7'd3, 7'd4, 7'd7, 7'd8, 7'd14, 7'd57, 7'd58, 7'd54, 7'd64, 7'd67
  };

  // hid usage per logical key, row-major over the 4x14 layout
  localparam logic [7:0] HID_BY_KEY [56] = '{
    8'h35, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h2E, 8'h2A,
    8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18, 8'h0C, 8'h12, 8'h13, 8'h2F, 8'h30, 8'h31,
    8'hE1, 8'h39, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h33, 8'h34, 8'h28,
    8'hE0, 8'hE3, 8'hE2, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'h2C
  };

  // character rows, leftmost column first; a tab marks a key with no character
  localparam logic [111:0] PLAIN_ROWS [4] = '{
    "\1401234567890-=\t",
    "\tqwertyuiop[]\\",
    "\t\tasdfghjkl;'\t",
    "\t\t\tzxcvbnm,./ "
  };
  localparam logic [111:0] SHIFT_ROWS [4] = '{
    "~!@#$%^&*()_+\t",
    "\tQWERTYUIOP{}|",
    "\t\tASDFGHJKL:\"\t",
    "\t\t\tZXCVBNM<>? "
  };

  // one row of the directed stimulus
  typedef struct {
    bit         is_cfg;
    logic       cfg_idx;
    logic       cfg_val;
    logic [7:0] data;
    bit         typed;
    bit         typed_hit;
    result_t    typed_res;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = 1'b0;
  logic                  cfg_data = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = 8'h00;  // [7:0] event_byte
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [0] event_valid, [1] is_press, [2] is_modifier_key, [10:3] hid_code,
  // [17:11] char_code, [20:18] nav_key, [24:21] modifiers_now, [25] caps_state
  logic [OUT_DATA_W-1:0] m_tdata;

  // predicted key state and register copies
  logic [55:0] key_down = '0;
  logic [3:0]  mod_bits = '0;
  logic        caps_lock = 1'b0;
  logic        out_event_en = 1'b0;
  logic        out_nav_en = 1'b0;

  result_t  pending_results[$];
  dir_row_t dir_rows[$];
  int       errors = 0;
  int       quiet = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;

  key_event_to_keycode_translator_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver backpressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // logical key index of a key code, -1 when the code is dropped
  function automatic int key_index(input logic [6:0] code);
    int rr, rc;
    if (code == 7'd0) return -1;
    rr = (int'(code) - 1) / 10;
    rc = (int'(code) - 1) % 10;
    if (rr >= 7 || rc >= 8) return -1;
    return (rc % 4) * 14 + rr * 2 + ((rc > 3) ? 1 : 0);
  endfunction

  function automatic logic [6:0] row_char(input logic [111:0] row, input int c);
    logic [7:0] ch;
    ch = row[8 * (13 - c) +: 8];
    return (ch == TAB_HOLE) ? 7'd0 : ch[6:0];
  endfunction

  // key translation: updates the predicted state, gives the result if one is due
  task automatic translate_key(input logic [7:0] b, output bit took, output bit hit,
                               output result_t res);
    int         idx, r, c;
    bit         press, is_mod, letter, use_shift;
    logic [7:0] hid;
    logic [6:0] ch;
    logic [2:0] nav;
    took = 1'b0;
    hit = 1'b0;
    res = '0;
    press = b[7];
    idx = key_index(b[6:0]);
    if (idx < 0) return;
    // repeated press or release leaves everything as is
    if (key_down[idx] == press) return;
    took = 1'b1;
    key_down[idx] = press;
    r = idx / 14;
    c = idx % 14;
    // modifiers follow the key, caps lock toggles on press only
    if (r == 2 && c == 0) mod_bits[MOD_SHIFT_BIT] = press;
    else if (r == 3 && c == 0) mod_bits[MOD_CTRL_BIT] = press;
    else if (r == 3 && c == 2) mod_bits[MOD_ALT_BIT] = press;
    else if (r == 3 && c == 1) mod_bits[MOD_OPT_BIT] = press;
    else if (r == 2 && c == 1 && press) caps_lock = !caps_lock;
    // table lookup, letters honor caps lock
    hid = HID_BY_KEY[idx];
    is_mod = (hid == HID_LCTRL) || (hid == HID_LSHIFT) || (hid == HID_LALT) ||
             (hid == HID_LGUI) || (hid == HID_CAPS);
    ch = 7'd0;
    if (!is_mod) begin
      letter = (hid >= HID_LETTER_LO) && (hid <= HID_LETTER_HI);
      use_shift = letter ? (mod_bits[MOD_SHIFT_BIT] ^ caps_lock) : mod_bits[MOD_SHIFT_BIT];
      ch = use_shift ? row_char(SHIFT_ROWS[r], c) : row_char(PLAIN_ROWS[r], c);
    end
    // navigation on press only
    nav = NAV_NONE;
    if (press && out_nav_en) begin
      if (r == 2 && c == 11) nav = NAV_UP;
      else if (r == 3 && c == 11) nav = NAV_DOWN;
      else if (r == 3 && c == 10) nav = NAV_LEFT;
      else if (r == 3 && c == 12) nav = NAV_RIGHT;
      else if (r == 2 && c == 13) nav = NAV_ENTER;
    end
    if (!out_event_en && nav == NAV_NONE) return;
    hit = 1'b1;
    if (out_event_en) begin
      res.event_valid = 1'b1;
      res.is_press = press;
      res.is_modifier_key = is_mod;
      res.hid_code = hid;
      res.char_code = ch;
    end
    res.nav_key = nav;
    res.modifiers_now = mod_bits;
    res.caps_state = caps_lock;
  endtask

  function automatic result_t key_result(input bit ev, input bit pr, input bit md,
                                         input logic [7:0] hid, input logic [6:0] ch,
                                         input logic [2:0] nav, input logic [3:0] mods,
                                         input bit caps);
    result_t res;
    res.event_valid = ev;
    res.is_press = pr;
    res.is_modifier_key = md;
    res.hid_code = hid;
    res.char_code = ch;
    res.nav_key = nav;
    res.modifiers_now = mods;
    res.caps_state = caps;
    return res;
  endfunction

  function automatic dir_row_t row_cfg(input logic idx, input logic val);
    dir_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = val;
    return row;
  endfunction

  function automatic dir_row_t row_auto(input logic [7:0] data);
    dir_row_t row;
    row = '{default: '0};
    row.data = data;
    return row;
  endfunction

  function automatic dir_row_t row_none(input logic [7:0] data);
    dir_row_t row;
    row = row_auto(data);
    row.typed = 1'b1;
    return row;
  endfunction

  function automatic dir_row_t row_hit(input logic [7:0] data, input result_t res);
    dir_row_t row;
    row = row_none(data);
    row.typed_hit = 1'b1;
    row.typed_res = res;
    return row;
  endfunction

  // one slave beat with random idle cycles in front
  task automatic send_beat(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop sending, wait for every result, then let the pipeline empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_EVENT_OUT_EN) out_event_en = val;
    else out_nav_en = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // master side: compare each beat with the oldest expected result
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[RESULT_W-1:0]);
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none actual %0h", $time, m_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("event_valid", 8'(want.event_valid), 8'(got.event_valid));
        check_field("is_press", 8'(want.is_press), 8'(got.is_press));
        check_field("is_modifier_key", 8'(want.is_modifier_key), 8'(got.is_modifier_key));
        check_field("hid_code", want.hid_code, got.hid_code);
        check_field("char_code", 8'(want.char_code), 8'(got.char_code));
        check_field("nav_key", 8'(want.nav_key), 8'(got.nav_key));
        check_field("modifiers_now", 8'(want.modifiers_now), 8'(got.modifiers_now));
        check_field("caps_state", 8'(want.caps_state), 8'(got.caps_state));
        check_field("padding", 8'd0, 8'(m_tdata[OUT_DATA_W-1:RESULT_W]));
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    bit         took, hit;
    result_t    res;
    logic [7:0] b;
    logic [6:0] code;
    int         pick, idx, sent_n, hits_n;

    // directed rows: drops, repeats, modifiers, caps lock, navigation, widest code
    dir_rows.push_back(row_cfg(CFG_EVENT_OUT_EN, 1'b1));
    dir_rows.push_back(row_cfg(CFG_NAV_OUT_EN, 1'b1));
    dir_rows.push_back(row_none(8'h00));
    dir_rows.push_back(row_none(8'h80));
    dir_rows.push_back(row_none(8'hFF));
    dir_rows.push_back(row_none(8'hC7));
    dir_rows.push_back(row_none(8'h89));
    dir_rows.push_back(row_none(8'h01));
    dir_rows.push_back(row_hit(8'h81, key_result(1'b1, 1'b1, 1'b0, 8'h35, 7'h60, NAV_NONE,
                                                 4'h0, 1'b0)));
    dir_rows.push_back(row_none(8'h81));
    dir_rows.push_back(row_hit(8'h01, key_result(1'b1, 1'b0, 1'b0, 8'h35, 7'h60, NAV_NONE,
                                                 4'h0, 1'b0)));
    dir_rows.push_back(row_hit(8'h83, key_result(1'b1, 1'b1, 1'b1, 8'hE1, 7'h00, NAV_NONE,
                                                 4'h1, 1'b0)));
    dir_rows.push_back(row_auto(8'h8D));
    dir_rows.push_back(row_auto(8'h85));
    dir_rows.push_back(row_auto(8'h87));
    dir_rows.push_back(row_auto(8'h03));
    dir_rows.push_back(row_auto(8'h0D));
    dir_rows.push_back(row_auto(8'h84));
    dir_rows.push_back(row_auto(8'h88));
    dir_rows.push_back(row_auto(8'h8E));
    dir_rows.push_back(row_auto(8'hB9));
    dir_rows.push_back(row_auto(8'hBA));
    dir_rows.push_back(row_auto(8'hB6));
    dir_rows.push_back(row_auto(8'hC0));
    dir_rows.push_back(row_auto(8'hC3));
    dir_rows.push_back(row_auto(8'hC4));
    dir_rows.push_back(row_auto(8'h39));
    dir_rows.push_back(row_cfg(CFG_EVENT_OUT_EN, 1'b0));
    dir_rows.push_back(row_auto(8'hB9));
    dir_rows.push_back(row_auto(8'h44));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle();
        cfg_write(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
      end else begin
        send_beat(dir_rows[i].data);
        translate_key(dir_rows[i].data, took, hit, res);
        if (dir_rows[i].typed) begin
          hit = dir_rows[i].typed_hit;
          res = dir_rows[i].typed_res;
        end
        if (hit) pending_results.push_back(res);
      end
    end

    // random phases over all register settings and idle mixes
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      cfg_write(CFG_EVENT_OUT_EN, PH_EVENT[ph][0]);
      cfg_write(CFG_NAV_OUT_EN, PH_NAV[ph][0]);
      send_idle_pct = PH_SEND_IDLE[ph];
      stall_pct = PH_STALL[ph];
      sent_n = 0;
      hits_n = 0;
      while (sent_n < PH_ITEMS[ph] ||
             (hits_n < MIN_PHASE_HITS && (PH_EVENT[ph] != 0 || PH_NAV[ph] != 0))) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          // noise: any byte at all
          b = 8'($urandom_range(0, 255));
        end else begin
          if (pick < 40) code = HOT_CODES[$urandom_range(0, 9)];
          else code = 7'($urandom_range(0, 6) * 10 + $urandom_range(0, 7) + 1);
          idx = key_index(code);
          // mostly real key changes, some repeats
          b = {($urandom_range(0, 99) < 85) ? !key_down[idx] : key_down[idx], code};
        end
        send_beat(b);
        translate_key(b, took, hit, res);
        if (hit) begin
          pending_results.push_back(res);
          hits_n++;
        end
        sent_n++;
        if (ph == PAUSE_PHASE && sent_n == PH_ITEMS[ph] / 2) settle();
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
